// ----- src/greedy_interval_selection_core_macros.svh -----
// assertion macros used by the checker file of greedy_interval_selection_core
// no dependencies
`ifndef GREEDY_INTERVAL_SELECTION_CORE_MACROS_SVH
`define GREEDY_INTERVAL_SELECTION_CORE_MACROS_SVH

// same-cycle implication
`define GIS_ASSERT_IMP(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: lbl");

// next-cycle implication
`define GIS_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: lbl");

`endif

// ----- src/gis_pkg.sv -----
// package of greedy_interval_selection_core: field widths, defaults, cell control type
// no dependencies
`default_nettype none

package gis_pkg;

   localparam int TIME_W            = 16;
   localparam int COUNT_W           = 7;
   localparam int MAX_INTERVALS_DEF = 64;
   localparam int TIME_BITS_DEF     = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   typedef struct packed {
      logic insert;
      logic shift_down;
      logic occupied;
      logic prev_occupied;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- src/gis_if.sv -----
// request and response channel interfaces of greedy_interval_selection_core
// depends on gis_pkg
`default_nettype none

interface gis_req_if;
   logic                          valid;
   logic                          ready;
   logic [gis_pkg::TIME_W-1:0]    start_time;
   logic [gis_pkg::TIME_W-1:0]    end_time;
   logic                          last_interval;

   modport source (output valid, output start_time, output end_time,
                   output last_interval, input ready);
   modport sink   (input valid, input start_time, input end_time,
                   input last_interval, output ready);
endinterface

interface gis_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gis_pkg::COUNT_W-1:0]   selected_count;
   logic                          overflow;

   modport source (output valid, output selected_count, output overflow, input ready);
   modport sink   (input valid, input selected_count, input overflow, output ready);
endinterface

`default_nettype wire

// ----- src/gis_cell.sv -----
// one cell of the sorted interval chain: holds one (start, end) pair
// depends on gis_pkg
`default_nettype none

module gis_cell #(
   parameter int TIME_BITS = gis_pkg::TIME_BITS_DEF
) (
   input  logic                   clock,
   input  gis_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_greater,
   input  logic [TIME_BITS-1:0]   prev_start,
   input  logic [TIME_BITS-1:0]   prev_finish,
   input  logic [TIME_BITS-1:0]   next_start,
   input  logic [TIME_BITS-1:0]   next_finish,
   input  logic [TIME_BITS-1:0]   new_start,
   input  logic [TIME_BITS-1:0]   new_finish,
   output logic [TIME_BITS-1:0]   start_q,
   output logic [TIME_BITS-1:0]   finish_q,
   output logic                   greater
);
   import gis_pkg::*;

   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] finish_ff, finish_in;

   assign greater  = ctrl.occupied && (finish_ff > new_finish);
   assign start_q  = start_ff;
   assign finish_q = finish_ff;

   always_comb begin
      start_in  = start_ff;
      finish_in = finish_ff;
      if (ctrl.shift_down) begin
         start_in  = next_start;
         finish_in = next_finish;
      end else if (ctrl.insert) begin
         if (prev_greater) begin
            start_in  = prev_start;
            finish_in = prev_finish;
         end else if (greater || (!ctrl.occupied && ctrl.prev_occupied)) begin
            start_in  = new_start;
            finish_in = new_finish;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff  <= start_in;
      finish_ff <= finish_in;
   end

endmodule

`default_nettype wire

// ----- src/greedy_interval_selection_core.sv -----
// Load: one interval transaction per cycle while in the load state, inserted in end order.
// After the marked transaction the chain shifts toward cell 0 once per stored
// interval; the scan then ends and the result is registered once the response
// register is free or being taken. No request is taken from the marked
// transaction until the response is registered.
// Synchronous reset clears the fill count, overflow flag, state and response valid.
`default_nettype none

module greedy_interval_selection_core #(
   parameter int MAX_INTERVALS = gis_pkg::MAX_INTERVALS_DEF,
   parameter int TIME_BITS     = gis_pkg::TIME_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gis_req_if.sink    req_chan,
   gis_rsp_if.source  rsp_chan
);
   import gis_pkg::*;

   localparam int CNT_W     = $clog2(MAX_INTERVALS + 1);
   localparam int KEEP_BITS = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;

   typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_DONE} state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     chosen_ff, chosen_in;
   logic [TIME_BITS-1:0] limit_ff, limit_in;
   logic                 overflow_ff, overflow_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   logic                 accept;
   logic                 full;
   logic                 scanning;
   logic [TIME_BITS-1:0] new_start, new_finish;
   logic [31:0]          chosen_wide;

   logic [TIME_BITS-1:0]    cell_start  [MAX_INTERVALS];
   logic [TIME_BITS-1:0]    cell_finish [MAX_INTERVALS];
   logic [MAX_INTERVALS-1:0] cell_greater;
   logic [MAX_INTERVALS-1:0] occupied;
   cell_ctrl_type           cell_ctrl   [MAX_INTERVALS];

   assign req_chan.ready          = (state_ff == ST_LOAD);
   assign accept                  = req_chan.valid && req_chan.ready;
   assign full                    = (count_ff == CNT_W'(MAX_INTERVALS));
   assign scanning                = (state_ff == ST_SCAN) && (count_ff != '0);
   assign new_start  = TIME_BITS'(req_chan.start_time[KEEP_BITS-1:0]);
   assign new_finish = TIME_BITS'(req_chan.end_time[KEEP_BITS-1:0]);

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.selected_count = rsp_count_ff;
   assign rsp_chan.overflow       = rsp_overflow_ff;

   for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
      assign occupied[i]                = (CNT_W'(i) < count_ff);
      assign cell_ctrl[i].insert        = accept && !full;
      assign cell_ctrl[i].shift_down    = scanning;
      assign cell_ctrl[i].occupied      = occupied[i];
      if (i == 0) begin : g_head
         assign cell_ctrl[i].prev_occupied = 1'b1;
      end else begin : g_body
         assign cell_ctrl[i].prev_occupied = occupied[i-1];
      end

      gis_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[i]),
         .prev_greater ((i == 0) ? 1'b0 : cell_greater[(i == 0) ? 0 : i-1]),
         .prev_start   (cell_start[(i == 0) ? 0 : i-1]),
         .prev_finish  (cell_finish[(i == 0) ? 0 : i-1]),
         .next_start   (cell_start[(i == MAX_INTERVALS-1) ? i : i+1]),
         .next_finish  (cell_finish[(i == MAX_INTERVALS-1) ? i : i+1]),
         .new_start    (new_start),
         .new_finish   (new_finish),
         .start_q      (cell_start[i]),
         .finish_q     (cell_finish[i]),
         .greater      (cell_greater[i])
      );
   end

   assign chosen_wide = 32'(chosen_ff);

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      chosen_in       = chosen_ff;
      limit_in        = limit_ff;
      overflow_in     = overflow_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_overflow_in = rsp_overflow_ff;

      if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_chan.last_interval) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
               if ((chosen_ff == '0) || (cell_start[0] > limit_ff)) begin
                  chosen_in = chosen_ff + CNT_W'(1);
                  limit_in  = cell_finish[0];
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_count_in    = (chosen_wide > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                : chosen_wide[COUNT_W-1:0];
               rsp_overflow_in = overflow_ff;
               overflow_in     = 1'b0;
               chosen_in       = '0;
               state_in        = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         chosen_ff    <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chosen_ff    <= chosen_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff        <= limit_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

endmodule

`default_nettype wire

// ----- src/gis_checker.sv -----
// port-level checks of greedy_interval_selection_core, bound to the top level
// depends on gis_pkg and greedy_interval_selection_core_macros.svh
`default_nettype none
`include "greedy_interval_selection_core_macros.svh"

module gis_checker #(
   parameter int MAX_INTERVALS = gis_pkg::MAX_INTERVALS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_last,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [gis_pkg::COUNT_W-1:0] rsp_count
);
   import gis_pkg::*;

   // stalled response holds
   `GIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_count))
   // marked transaction closes the batch, no request taken next cycle
   `GIS_ASSERT_NEXT(a_batch_close, clock, reset, req_valid && req_ready && req_last, !req_ready)
   // a batch holds at least one stored interval
   `GIS_ASSERT_IMP(a_count_nonzero, clock, reset, rsp_valid, rsp_count != '0)
   `GIS_ASSERT_IMP(a_count_bound, clock, reset, rsp_valid, 32'(rsp_count) <= MAX_INTERVALS)

endmodule

bind greedy_interval_selection_core gis_checker #(
   .MAX_INTERVALS (MAX_INTERVALS)
) u_gis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_last  (req_chan.last_interval),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_count (rsp_chan.selected_count)
);

`default_nettype wire

// ----- tb/greedy_interval_selection_core_tb.sv -----
// testbench of greedy_interval_selection_core: batches of intervals are driven in, and each
// selection count is checked against an in-bench earliest-finish predictor
// depends on gis_pkg, gis_if and greedy_interval_selection_core
`timescale 1ns / 100ps

module greedy_interval_selection_core_tb;
   import gis_pkg::*;

   localparam int HALF_PERIOD   = 4;
   localparam int DEPTH         = MAX_INTERVALS_DEF;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = DEPTH + 8;

   localparam int STYLE_FULL   = 0;
   localparam int STYLE_NARROW = 1;
   localparam int STYLE_TOP    = 2;

   typedef struct packed {
      logic [COUNT_W-1:0] selected_count;
      logic               overflow;
   } selection_result_type;

   class selection_scoreboard;
      logic [TIME_W-1:0] start_by_end[DEPTH];
      logic [TIME_W-1:0] end_sorted[DEPTH];
      int                loaded;
      bit                dropped_seen;
      selection_result_type expected_counts[$];
      int                errors;

      function new();
         loaded       = 0;
         dropped_seen = 0;
         errors       = 0;
      endfunction

      function logic [COUNT_W-1:0] count_selected();
         int                chosen;
         logic [TIME_W-1:0] horizon;
         if (loaded == 0) return '0;
         chosen  = 1;
         horizon = end_sorted[0];
         for (int i = 1; i < loaded; i++) begin
            if (start_by_end[i] > horizon) begin
               horizon = end_sorted[i];
               chosen++;
            end
         end
         if (chosen > int'(COUNT_MAX)) chosen = int'(COUNT_MAX);
         return COUNT_W'(chosen);
      endfunction

      function void note_interval(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e, logic is_last);
         int                pos;
         selection_result_type res;
         if (loaded < DEPTH) begin
            pos = loaded;
            // ties stay in arrival order
            while (pos > 0 && end_sorted[pos-1] > e) begin
               start_by_end[pos] = start_by_end[pos-1];
               end_sorted[pos]   = end_sorted[pos-1];
               pos--;
            end
            start_by_end[pos] = s;
            end_sorted[pos]   = e;
            loaded++;
         end else begin
            dropped_seen = 1;
         end
         if (is_last) begin
            res.selected_count = count_selected();
            res.overflow       = dropped_seen;
            expected_counts.push_back(res);
            loaded       = 0;
            dropped_seen = 0;
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t ns mismatch: %s", $time, what);
      endtask

      task check_result(logic [COUNT_W-1:0] count, logic ovf);
         selection_result_type exp;
         if (expected_counts.size() == 0) begin
            report_mismatch($sformatf("unexpected result count=%0d overflow=%0b", count, ovf));
         end else begin
            exp = expected_counts.pop_front();
            if (count !== exp.selected_count)
               report_mismatch($sformatf("selected_count %0d, expected %0d",
                                         count, exp.selected_count));
            if (ovf !== exp.overflow)
               report_mismatch($sformatf("overflow %0b, expected %0b", ovf, exp.overflow));
         end
      endtask

      function int pending();
         return expected_counts.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   gis_req_if req_chan ();
   gis_rsp_if rsp_chan ();

   greedy_interval_selection_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   selection_scoreboard sb = new();

   int src_idle_pct;
   int sink_stall_pct;
   int items_sent;
   int quiet_cycles;
   int src_idle_by_phase[4]  = '{0, 81, 0, 37};
   int sink_stall_by_phase[4] = '{0, 0, 81, 37};

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            sb.note_interval(req_chan.start_time, req_chan.end_time, req_chan.last_interval);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result(rsp_chan.selected_count, rsp_chan.overflow);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < STALL_LIMIT);
      $display("greedy_interval_selection_core_tb failed");
      $finish;
   end

   task automatic send_interval(logic [TIME_W-1:0] s, logic [TIME_W-1:0] e, logic is_last);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.start_time    <= s;
      req_chan.end_time      <= e;
      req_chan.last_interval <= is_last;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_batch(int count, int style);
      logic [TIME_W-1:0] s;
      logic [TIME_W-1:0] e;
      for (int i = 0; i < count; i++) begin
         case (style)
            STYLE_NARROW: begin
               s = TIME_W'($urandom_range(0, 300));
               e = s + TIME_W'($urandom_range(0, 25));
               // occasional start after end, wrapping near zero
               if ($urandom_range(0, 9) == 0) e = s - TIME_W'($urandom_range(1, 5));
            end
            STYLE_TOP: begin
               s = 16'hFFFF - TIME_W'($urandom_range(0, 40));
               e = 16'hFFFF - TIME_W'($urandom_range(0, 40));
            end
            default: begin
               s = TIME_W'($urandom_range(0, 65535));
               e = TIME_W'($urandom_range(0, 65535));
            end
         endcase
         send_interval(s, e, i == count - 1);
      end
   endtask

   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int phase_start;
      int batch_size;
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.start_time    = '0;
      req_chan.end_time      = '0;
      req_chan.last_interval = 1'b0;
      rsp_chan.ready         = 1'b0;
      src_idle_pct           = 0;
      sink_stall_pct         = 0;
      items_sent             = 0;
      quiet_cycles           = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single interval with start after end
      send_interval(16'hFFFF, 16'h0000, 1'b1);
      // start equal to last end is not chosen, equal ends keep arrival order
      send_interval(16'd5, 16'd10, 1'b0);
      send_interval(16'd10, 16'd20, 1'b0);
      send_interval(16'd11, 16'd20, 1'b1);
      // extremes of both fields
      send_interval(16'h0000, 16'h0000, 1'b0);
      send_interval(16'hFFFF, 16'hFFFF, 1'b0);
      send_interval(16'h0001, 16'hFFFF, 1'b0);
      send_interval(16'hFFFF, 16'h0000, 1'b1);
      // reverse arrival of disjoint intervals
      send_interval(16'd30, 16'd39, 1'b0);
      send_interval(16'd20, 16'd29, 1'b0);
      send_interval(16'd10, 16'd19, 1'b0);
      send_interval(16'd0, 16'd9, 1'b1);
      // nested intervals
      send_interval(16'd0, 16'd100, 1'b0);
      send_interval(16'd10, 16'd20, 1'b0);
      send_interval(16'd30, 16'd40, 1'b0);
      send_interval(16'd50, 16'd60, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         src_idle_pct   = src_idle_by_phase[phase];
         sink_stall_pct = sink_stall_by_phase[phase];
         phase_start    = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 6)
               batch_size = $urandom_range(63, 70);
            else
               batch_size = $urandom_range(1, 12);
            send_batch(batch_size, $urandom_range(STYLE_FULL, STYLE_TOP));
         end
         // hold off until the block has answered every batch
         wait_all_results();
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("greedy_interval_selection_core_tb passed");
      end else begin
         $display("greedy_interval_selection_core_tb failed");
      end
      $finish;
   end

endmodule
